// ===== rtl/umeu_pkg.sv =====
// shared types and constants for the universal machine execute unit
// no dependencies; used by the interfaces and every rtl module
package umeu_pkg;

    localparam int WORD_W    = 32;
    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int OPC_W     = 4;
    localparam int ACT_W     = 4;
    localparam int IMM_W     = 25;
    localparam int CHAR_W    = 8;

    // instruction field positions
    localparam int OPC_LSB   = 28;
    localparam int ORTHO_LSB = 25;
    localparam int FLD_A_LSB = 6;
    localparam int FLD_B_LSB = 3;
    localparam int FLD_C_LSB = 0;

    // opcodes
    localparam logic [OPC_W-1:0] OPC_CMOV     = 4'd0;
    localparam logic [OPC_W-1:0] OPC_INDEX    = 4'd1;
    localparam logic [OPC_W-1:0] OPC_AMEND    = 4'd2;
    localparam logic [OPC_W-1:0] OPC_ADD      = 4'd3;
    localparam logic [OPC_W-1:0] OPC_MUL      = 4'd4;
    localparam logic [OPC_W-1:0] OPC_DIV      = 4'd5;
    localparam logic [OPC_W-1:0] OPC_NAND     = 4'd6;
    localparam logic [OPC_W-1:0] OPC_HALT     = 4'd7;
    localparam logic [OPC_W-1:0] OPC_ALLOC    = 4'd8;
    localparam logic [OPC_W-1:0] OPC_ABANDON  = 4'd9;
    localparam logic [OPC_W-1:0] OPC_OUTPUT   = 4'd10;
    localparam logic [OPC_W-1:0] OPC_INPUT    = 4'd11;
    localparam logic [OPC_W-1:0] OPC_LOADPROG = 4'd12;
    localparam logic [OPC_W-1:0] OPC_ORTHO    = 4'd13;

    // action codes on the result channel
    localparam logic [ACT_W-1:0] ACT_NONE     = 4'd0;
    localparam logic [ACT_W-1:0] ACT_READ     = 4'd1;
    localparam logic [ACT_W-1:0] ACT_WRITE    = 4'd2;
    localparam logic [ACT_W-1:0] ACT_MAP      = 4'd3;
    localparam logic [ACT_W-1:0] ACT_UNMAP    = 4'd4;
    localparam logic [ACT_W-1:0] ACT_OUTPUT   = 4'd5;
    localparam logic [ACT_W-1:0] ACT_INPUT    = 4'd6;
    localparam logic [ACT_W-1:0] ACT_LOADPROG = 4'd7;
    localparam logic [ACT_W-1:0] ACT_HALT     = 4'd8;

    // input op codes
    localparam logic OP_EXECUTE  = 1'b0;
    localparam logic OP_RESPONSE = 1'b1;

    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr0;
        logic [REG_IDX_W-1:0] addr1;
    } rf_rd_req_t;

    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr;
        logic [WORD_W-1:0]    data;
    } rf_wr_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== rtl/umeu_if.sv =====
// valid/ready channel interfaces for instruction/response beats and result beats
// depends on umeu_pkg
interface umeu_req_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [umeu_pkg::WORD_W-1:0] instruction_word;
    logic [umeu_pkg::WORD_W-1:0] response_value;
    logic                        response_eof;

    modport source (
        output valid, op, instruction_word, response_value, response_eof,
        input  ready
    );
    modport sink (
        input  valid, op, instruction_word, response_value, response_eof,
        output ready
    );
endinterface

interface umeu_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [umeu_pkg::ACT_W-1:0]  action;
    logic [umeu_pkg::WORD_W-1:0] segment_id;
    logic [umeu_pkg::WORD_W-1:0] offset;
    logic [umeu_pkg::WORD_W-1:0] store_value;
    logic [umeu_pkg::WORD_W-1:0] next_pc;
    logic                        error_flag;

    modport source (
        output valid, action, segment_id, offset, store_value, next_pc, error_flag,
        input  ready
    );
    modport sink (
        input  valid, action, segment_id, offset, store_value, next_pc, error_flag,
        output ready
    );
endinterface

// ===== rtl/umeu_regfile.sv =====
// register file memory: two registered read ports, one write port
// depends on umeu_pkg; per-entry valid bits give the all-zero reset contents
module umeu_regfile (
    input  logic                        clk,
    input  logic                        rst_n,
    input  umeu_pkg::rf_rd_req_t        rd_req,
    input  umeu_pkg::rf_wr_req_t        wr_req,
    output logic [umeu_pkg::WORD_W-1:0] rd_data0,
    output logic [umeu_pkg::WORD_W-1:0] rd_data1
);

    logic [umeu_pkg::WORD_W-1:0]    mem [umeu_pkg::REG_COUNT];
    logic [umeu_pkg::REG_COUNT-1:0] valid_reg;
    logic [umeu_pkg::WORD_W-1:0]    rd_data0_reg;
    logic [umeu_pkg::WORD_W-1:0]    rd_data1_reg;

    always_ff @(posedge clk)
    begin
        if (wr_req.en)
        begin
            mem[wr_req.addr] <= wr_req.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_data0_reg <= '0;
            rd_data1_reg <= '0;
        end
        else
        begin
            if (wr_req.en)
            begin
                valid_reg[wr_req.addr] <= 1'b1;
            end
            // unwritten entries read as zero
            if (rd_req.en)
            begin
                rd_data0_reg <= valid_reg[rd_req.addr0] ? mem[rd_req.addr0] : '0;
                rd_data1_reg <= valid_reg[rd_req.addr1] ? mem[rd_req.addr1] : '0;
            end
        end
    end

    assign rd_data0 = rd_data0_reg;
    assign rd_data1 = rd_data1_reg;

endmodule

// ===== rtl/umeu_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on umeu_pkg; divisor must be nonzero when started
module umeu_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [umeu_pkg::WORD_W-1:0] dividend,
    input  logic [umeu_pkg::WORD_W-1:0] divisor,
    output umeu_pkg::div_status_t       status,
    output logic [umeu_pkg::WORD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(umeu_pkg::WORD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(umeu_pkg::WORD_W - 1);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [umeu_pkg::WORD_W-1:0] rem_reg, rem_next;
    logic [umeu_pkg::WORD_W-1:0] quo_reg, quo_next;
    logic [umeu_pkg::WORD_W-1:0] dsr_reg, dsr_next;
    logic [umeu_pkg::WORD_W:0]   trial;
    logic [umeu_pkg::WORD_W:0]   diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, quo_reg[umeu_pkg::WORD_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            if (!diff[umeu_pkg::WORD_W])
            begin
                rem_next = diff[umeu_pkg::WORD_W-1:0];
                quo_next = {quo_reg[umeu_pkg::WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[umeu_pkg::WORD_W-1:0];
                quo_next = {quo_reg[umeu_pkg::WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dsr_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dsr_reg  <= dsr_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

// ===== rtl/universal_machine_execute_unit.sv =====
// top level of the universal machine execute unit: sequencer, decode and result register
// depends on umeu_pkg, umeu_if, umeu_regfile and umeu_div
//
// The unit runs one beat at a time around a register file held in a small synchronous
// memory with registered read ports. An instruction beat is accepted, then passes through
// ST_READ, reading registers B and C, ST_OPND, capturing them (and reading A for the array
// amendment), ST_EXEC, executing, and ST_FINISH, retiring into the result register once it
// is free and writing back; only then is a new instruction taken. Divide waits in ST_DIV for
// the bit-serial divider (one quotient bit per cycle). Response beats, and instructions that
// arrive while a read, map or input request is still outstanding, skip the register reads
// and go to ST_FINISH. Only index, map and input wait for a response beat; the register
// named by the request is written when it arrives. The result register lets the
// next beat be accepted while a finished result is still waiting on the output side.
module universal_machine_execute_unit (
    input  logic             clk,
    input  logic             rst_n,
    umeu_req_if.sink         req,
    umeu_rsp_if.source       rsp
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_OPND,
        ST_EXEC,
        ST_DIV,
        ST_FINISH
    } state_t;

    localparam int W  = umeu_pkg::WORD_W;
    localparam int RW = umeu_pkg::REG_IDX_W;

    state_t                    state_reg, state_next;

    // architectural state outside the register file
    logic [W-1:0]              pc_reg, pc_next;
    logic                      pend_valid_reg, pend_valid_next;
    logic [RW-1:0]             pend_dest_reg, pend_dest_next;

    // item being worked on
    logic [W-1:0]              word_reg, word_next;
    logic [W-1:0]              vb_reg, vb_next;
    logic [W-1:0]              vc_reg, vc_next;

    // staged result and side effects, committed in ST_FINISH
    logic [umeu_pkg::ACT_W-1:0] res_action_reg, res_action_next;
    logic [W-1:0]              res_seg_reg, res_seg_next;
    logic [W-1:0]              res_off_reg, res_off_next;
    logic [W-1:0]              res_sv_reg, res_sv_next;
    logic [W-1:0]              res_npc_reg, res_npc_next;
    logic                      res_err_reg, res_err_next;
    logic                      res_we_reg, res_we_next;
    logic [RW-1:0]             res_waddr_reg, res_waddr_next;
    logic [W-1:0]              res_wdata_reg, res_wdata_next;
    logic                      res_pvalid_reg, res_pvalid_next;
    logic [RW-1:0]             res_pdest_reg, res_pdest_next;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic [umeu_pkg::ACT_W-1:0] out_action_reg, out_action_next;
    logic [W-1:0]              out_seg_reg, out_seg_next;
    logic [W-1:0]              out_off_reg, out_off_next;
    logic [W-1:0]              out_sv_reg, out_sv_next;
    logic [W-1:0]              out_npc_reg, out_npc_next;
    logic                      out_err_reg, out_err_next;

    // register file and divider hookup
    umeu_pkg::rf_rd_req_t      rd_req;
    umeu_pkg::rf_wr_req_t      wr_req;
    logic [W-1:0]              rd_data0;
    logic [W-1:0]              rd_data1;
    logic                      div_start;
    umeu_pkg::div_status_t     div_status;
    logic [W-1:0]              div_quotient;

    // decode of the held instruction
    logic [umeu_pkg::OPC_W-1:0] opc;
    logic [RW-1:0]             fld_a;
    logic [RW-1:0]             fld_b;
    logic [RW-1:0]             fld_c;
    logic [RW-1:0]             fld_ortho;
    logic [2*W-1:0]            product;

    assign opc       = word_reg[umeu_pkg::OPC_LSB +: umeu_pkg::OPC_W];
    assign fld_a     = word_reg[umeu_pkg::FLD_A_LSB +: RW];
    assign fld_b     = word_reg[umeu_pkg::FLD_B_LSB +: RW];
    assign fld_c     = word_reg[umeu_pkg::FLD_C_LSB +: RW];
    assign fld_ortho = word_reg[umeu_pkg::ORTHO_LSB +: RW];
    assign product   = vb_reg * vc_reg;

    umeu_regfile u_regfile (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_req   (rd_req),
        .wr_req   (wr_req),
        .rd_data0 (rd_data0),
        .rd_data1 (rd_data1)
    );

    umeu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (vb_reg),
        .divisor  (vc_reg),
        .status   (div_status),
        .quotient (div_quotient)
    );

    // input side takes a beat only between items
    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        pc_next         = pc_reg;
        pend_valid_next = pend_valid_reg;
        pend_dest_next  = pend_dest_reg;
        word_next       = word_reg;
        vb_next         = vb_reg;
        vc_next         = vc_reg;
        res_action_next = res_action_reg;
        res_seg_next    = res_seg_reg;
        res_off_next    = res_off_reg;
        res_sv_next     = res_sv_reg;
        res_npc_next    = res_npc_reg;
        res_err_next    = res_err_reg;
        res_we_next     = res_we_reg;
        res_waddr_next  = res_waddr_reg;
        res_wdata_next  = res_wdata_reg;
        res_pvalid_next = res_pvalid_reg;
        res_pdest_next  = res_pdest_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_action_next = out_action_reg;
        out_seg_next    = out_seg_reg;
        out_off_next    = out_off_reg;
        out_sv_next     = out_sv_reg;
        out_npc_next    = out_npc_reg;
        out_err_next    = out_err_reg;
        rd_req          = '0;
        wr_req          = '0;
        div_start       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    word_next       = req.instruction_word;
                    res_action_next = umeu_pkg::ACT_NONE;
                    res_seg_next    = '0;
                    res_off_next    = '0;
                    res_sv_next     = '0;
                    res_npc_next    = pc_reg;
                    res_err_next    = 1'b0;
                    res_we_next     = 1'b0;
                    res_waddr_next  = pend_dest_reg;
                    res_wdata_next  = '0;
                    res_pvalid_next = pend_valid_reg;
                    res_pdest_next  = pend_dest_reg;
                    if (req.op == umeu_pkg::OP_RESPONSE)
                    begin
                        // response completes the outstanding request, or flags an error
                        if (pend_valid_reg)
                        begin
                            res_we_next     = 1'b1;
                            res_wdata_next  = req.response_eof ? '1 : req.response_value;
                            res_pvalid_next = 1'b0;
                        end
                        else
                        begin
                            res_err_next = 1'b1;
                        end
                        state_next = ST_FINISH;
                    end
                    else if (pend_valid_reg)
                    begin
                        // instruction ignored while a request is outstanding
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end

            ST_READ:
            begin
                rd_req.en    = 1'b1;
                rd_req.addr0 = fld_b;
                rd_req.addr1 = fld_c;
                state_next   = ST_OPND;
            end

            ST_OPND:
            begin
                vb_next = rd_data0;
                vc_next = rd_data1;
                // array amendment also needs register A as the segment
                if (opc == umeu_pkg::OPC_AMEND)
                begin
                    rd_req.en    = 1'b1;
                    rd_req.addr0 = fld_a;
                    rd_req.addr1 = fld_a;
                end
                state_next = ST_EXEC;
            end

            ST_EXEC:
            begin
                res_npc_next   = pc_reg + W'(1);
                res_waddr_next = fld_a;
                state_next     = ST_FINISH;
                case (opc)
                    umeu_pkg::OPC_CMOV:
                    begin
                        res_we_next    = (vc_reg != '0);
                        res_wdata_next = vb_reg;
                    end
                    umeu_pkg::OPC_INDEX:
                    begin
                        res_action_next = umeu_pkg::ACT_READ;
                        res_seg_next    = vb_reg;
                        res_off_next    = vc_reg;
                        res_pvalid_next = 1'b1;
                        res_pdest_next  = fld_a;
                    end
                    umeu_pkg::OPC_AMEND:
                    begin
                        res_action_next = umeu_pkg::ACT_WRITE;
                        res_seg_next    = rd_data0;
                        res_off_next    = vb_reg;
                        res_sv_next     = vc_reg;
                    end
                    umeu_pkg::OPC_ADD:
                    begin
                        res_we_next    = 1'b1;
                        res_wdata_next = vb_reg + vc_reg;
                    end
                    umeu_pkg::OPC_MUL:
                    begin
                        res_we_next    = 1'b1;
                        res_wdata_next = product[W-1:0];
                    end
                    umeu_pkg::OPC_DIV:
                    begin
                        if (vc_reg == '0)
                        begin
                            res_we_next    = 1'b1;
                            res_wdata_next = '1;
                            res_err_next   = 1'b1;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    umeu_pkg::OPC_NAND:
                    begin
                        res_we_next    = 1'b1;
                        res_wdata_next = ~(vb_reg & vc_reg);
                    end
                    umeu_pkg::OPC_HALT:
                    begin
                        res_action_next = umeu_pkg::ACT_HALT;
                        res_npc_next    = pc_reg;
                    end
                    umeu_pkg::OPC_ALLOC:
                    begin
                        res_action_next = umeu_pkg::ACT_MAP;
                        res_seg_next    = vc_reg;
                        res_pvalid_next = 1'b1;
                        res_pdest_next  = fld_b;
                    end
                    umeu_pkg::OPC_ABANDON:
                    begin
                        res_action_next = umeu_pkg::ACT_UNMAP;
                        res_seg_next    = vc_reg;
                    end
                    umeu_pkg::OPC_OUTPUT:
                    begin
                        res_action_next = umeu_pkg::ACT_OUTPUT;
                        res_sv_next     = {{(W - umeu_pkg::CHAR_W){1'b0}},
                                           vc_reg[umeu_pkg::CHAR_W-1:0]};
                    end
                    umeu_pkg::OPC_INPUT:
                    begin
                        res_action_next = umeu_pkg::ACT_INPUT;
                        res_pvalid_next = 1'b1;
                        res_pdest_next  = fld_c;
                    end
                    umeu_pkg::OPC_LOADPROG:
                    begin
                        res_action_next = umeu_pkg::ACT_LOADPROG;
                        res_seg_next    = vb_reg;
                        res_npc_next    = vc_reg;
                    end
                    umeu_pkg::OPC_ORTHO:
                    begin
                        res_we_next    = 1'b1;
                        res_waddr_next = fld_ortho;
                        res_wdata_next = {{(W - umeu_pkg::IMM_W){1'b0}},
                                          word_reg[umeu_pkg::IMM_W-1:0]};
                    end
                    default:
                    begin
                        // undefined opcodes halt with an error
                        res_action_next = umeu_pkg::ACT_HALT;
                        res_npc_next    = pc_reg;
                        res_err_next    = 1'b1;
                    end
                endcase
            end

            ST_DIV:
            begin
                if (div_status.done)
                begin
                    res_we_next    = 1'b1;
                    res_wdata_next = div_quotient;
                    state_next     = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                // retire once the result register is free or being drained
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_action_next = res_action_reg;
                    out_seg_next    = res_seg_reg;
                    out_off_next    = res_off_reg;
                    out_sv_next     = res_sv_reg;
                    out_npc_next    = res_npc_reg;
                    out_err_next    = res_err_reg;
                    wr_req.en       = res_we_reg;
                    wr_req.addr     = res_waddr_reg;
                    wr_req.data     = res_wdata_reg;
                    pc_next         = res_npc_reg;
                    pend_valid_next = res_pvalid_reg;
                    pend_dest_next  = res_pdest_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pc_reg         <= '0;
            pend_valid_reg <= 1'b0;
            pend_dest_reg  <= '0;
            word_reg       <= '0;
            vb_reg         <= '0;
            vc_reg         <= '0;
            res_action_reg <= umeu_pkg::ACT_NONE;
            res_seg_reg    <= '0;
            res_off_reg    <= '0;
            res_sv_reg     <= '0;
            res_npc_reg    <= '0;
            res_err_reg    <= 1'b0;
            res_we_reg     <= 1'b0;
            res_waddr_reg  <= '0;
            res_wdata_reg  <= '0;
            res_pvalid_reg <= 1'b0;
            res_pdest_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_action_reg <= umeu_pkg::ACT_NONE;
            out_seg_reg    <= '0;
            out_off_reg    <= '0;
            out_sv_reg     <= '0;
            out_npc_reg    <= '0;
            out_err_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pc_reg         <= pc_next;
            pend_valid_reg <= pend_valid_next;
            pend_dest_reg  <= pend_dest_next;
            word_reg       <= word_next;
            vb_reg         <= vb_next;
            vc_reg         <= vc_next;
            res_action_reg <= res_action_next;
            res_seg_reg    <= res_seg_next;
            res_off_reg    <= res_off_next;
            res_sv_reg     <= res_sv_next;
            res_npc_reg    <= res_npc_next;
            res_err_reg    <= res_err_next;
            res_we_reg     <= res_we_next;
            res_waddr_reg  <= res_waddr_next;
            res_wdata_reg  <= res_wdata_next;
            res_pvalid_reg <= res_pvalid_next;
            res_pdest_reg  <= res_pdest_next;
            out_valid_reg  <= out_valid_next;
            out_action_reg <= out_action_next;
            out_seg_reg    <= out_seg_next;
            out_off_reg    <= out_off_next;
            out_sv_reg     <= out_sv_next;
            out_npc_reg    <= out_npc_next;
            out_err_reg    <= out_err_next;
        end
    end

    // result beat
    assign rsp.valid       = out_valid_reg;
    assign rsp.action      = out_action_reg;
    assign rsp.segment_id  = out_seg_reg;
    assign rsp.offset      = out_off_reg;
    assign rsp.store_value = out_sv_reg;
    assign rsp.next_pc     = out_npc_reg;
    assign rsp.error_flag  = out_err_reg;

endmodule
